/* sv/pfv_pkg.sv */
`default_nettype none
package pfv_pkg;

	localparam int MAX_OBS   = 16;
	localparam int IDX_W     = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
	localparam int FRAC_BITS = 16;
	localparam int ID_BITS   = 2 * FRAC_BITS + 1;
	localparam int U_BITS    = 31 + FRAC_BITS;
	localparam int CFG_IDX_W = 3;
	localparam int ACC_W     = 38;
	localparam int DCNT_W    = 7;

	localparam logic [63:0] CAP_STAGE = 64'h4000_0000_0000_0000;
	localparam logic [63:0] CAP_TERM  = 64'h0000_0000_8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GOAL_X,
		CFG_GOAL_Y,
		CFG_GOAL_Z,
		CFG_ATT_GAIN,
		CFG_TOL
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FN_QUERY,
		FN_ADD,
		FN_REMOVE,
		FN_CLEAR
	} func_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_ED_RD,
		S_ED_CHK,
		S_ED_WR,
		S_Q_DIF,
		S_SQ_GO,
		S_SQ_WT,
		S_AT_CHK,
		S_AT_GO,
		S_AT_WT,
		S_OB_RD,
		S_OB_DIF,
		S_OB_OUT,
		S_OB_CHK,
		S_OB_NXT,
		S_SR_GO,
		S_SR_WT,
		S_DI_GO,
		S_DI_WT,
		S_DR_GO,
		S_DR_WT,
		S_T_GO,
		S_T_WT,
		S_U_GO,
		S_U_WT,
		S_M_GO,
		S_M_WT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [30:0] rad;
		logic [30:0] gain;
	} ent_t;

	function automatic logic [31:0] mag33(input logic [32:0] v);
		logic [32:0] n;
		n = v[32] ? (33'd0 - v) : v;
		return n[31:0];
	endfunction

	function automatic logic [63:0] mul_sat(input logic [127:0] p, input logic [63:0] cap);
		logic [63:0] r;
		r = p[63+FRAC_BITS:FRAC_BITS];
		if (|p[127:64+FRAC_BITS])
			return cap;
		return (r > cap) ? cap : r;
	endfunction

	function automatic logic [31:0] sat_out(input logic [ACC_W-1:0] a);
		if (!((&a[ACC_W-1:31]) || !(|a[ACC_W-1:31])))
			return a[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return a[31:0];
	endfunction

endpackage
`default_nettype wire

/* sv/potential_field_velocity_core.sv */
// Add and remove make at most one walk over the obstacle memory, and clear makes none. A query
// takes longer with the goal pull and for each empty slot, out-of-reach slot, slot failing the
// distance test and obstacle in reach.
// Throughput: one item at a time; the next item is taken as soon as the result is registered.
// Reset: arst_n clears the valid bits, the controller and the configuration to its defaults;
// the obstacle memory is not cleared.
`default_nettype none
module potential_field_velocity_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [15:0]                     obstacle_id,
	input  logic signed [31:0]              pos_x,
	input  logic signed [31:0]              pos_y,
	input  logic signed [31:0]              pos_z,
	input  logic [30:0]                     influence_radius,
	input  logic [30:0]                     repulse_gain,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              force_x,
	output logic signed [31:0]              force_y,
	output logic signed [31:0]              force_z,
	output logic                            id_found,
	output logic                            table_full,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);
	import pfv_pkg::*;

	state_t state_q, nxt;

	logic [31:0] goal_q [3];
	logic [30:0] again_q, tol_q;

	func_t       fn_q;
	logic [15:0] oid_q;
	logic [31:0] p_q [3];
	logic [30:0] rin_q, gin_q;

	logic [MAX_OBS-1:0] vld_q;
	ent_t               obs_mem [MAX_OBS];
	ent_t               rd_q;
	logic [IDX_W-1:0]   k_q, slot_q;
	logic               freev_q;

	logic [32:0]        dif_q [3];
	logic [1:0]         ax_q;
	logic               obs_q;
	logic [63:0]        s_q, tol2_q, r2_q;
	logic [30:0]        r_q, eg_q;
	logic [31:0]        q_q;
	logic [ID_BITS-1:0] invd_q, invr_q;
	logic [62:0]        t_q;
	logic [U_BITS-1:0]  u_q;
	logic [ACC_W-1:0]   acc_q [3];
	logic               found_q, full_q;

	logic        out_valid_q;
	logic [31:0] fo_q [3];
	logic        fnd_o_q, full_o_q;

	logic         mul_go, mbusy_q, mdone_q;
	logic [63:0]  mul_a, mul_b, ma_q, mb_q, pp_q;
	logic [2:0]   mc_q, pj;
	logic [1:0]   sh;
	logic [127:0] prod_q;

	logic              div_go, dbusy_q, ddone_q;
	logic [63:0]       div_n, dn_q, dqo_q;
	logic [31:0]       div_d, dd_q, dr_q;
	logic [DCNT_W-1:0] div_cnt, dcnt_q;
	logic [32:0]       rem_sh;
	logic              rem_ge;

	logic        sqrt_go, sbusy_q, sdone_q;
	logic [63:0] ss_q, sres_q, sbit_q, strial;

	logic        mem_rd, mem_wr, out_load;
	logic [31:0] mag_d [3];
	logic [31:0] mag_sel;
	logic        capf, hit, last, out_reach;
	logic [63:0] term_att, term_rep, tstage;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q[0] <= '0;
			goal_q[1] <= '0;
			goal_q[2] <= '0;
			again_q   <= 31'd65536;
			tol_q     <= 31'd66;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GOAL_X:   goal_q[0] <= cfg_data;
				CFG_GOAL_Y:   goal_q[1] <= cfg_data;
				CFG_GOAL_Z:   goal_q[2] <= cfg_data;
				CFG_ATT_GAIN: again_q   <= cfg_data[30:0];
				CFG_TOL:      tol_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_d[i] = mag33(dif_q[i]);
	end

	assign mag_sel   = mag_d[ax_q];
	assign capf      = mag_d[0][31] | mag_d[1][31] | mag_d[2][31];
	assign hit       = vld_q[k_q] && (rd_q.id == oid_q);
	assign last      = (k_q == IDX_W'(MAX_OBS - 1));
	assign out_reach = (mag_d[0] > {1'b0, r_q}) || (mag_d[1] > {1'b0, r_q}) ||
		(mag_d[2] > {1'b0, r_q});
	assign term_att  = mul_sat(prod_q, CAP_TERM);
	assign term_rep  = mul_sat(prod_q, CAP_TERM);
	assign tstage    = mul_sat(prod_q, CAP_STAGE);
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= nxt;
	end

	always_comb begin
		nxt     = state_q;
		mul_go  = 1'b0;
		div_go  = 1'b0;
		sqrt_go = 1'b0;
		mem_rd  = 1'b0;
		mem_wr  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_n   = {1'b1, 63'd0};
		div_d   = q_q;
		div_cnt = DCNT_W'(ID_BITS);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (func_t'(func))
						FN_QUERY:  nxt = S_Q_DIF;
						FN_CLEAR:  nxt = S_CLR;
						default:   nxt = S_ED_RD;
					endcase
				end
			end
			S_CLR:   nxt = S_FIN;
			S_ED_RD: begin
				mem_rd = 1'b1;
				nxt    = S_ED_CHK;
			end
			S_ED_CHK: begin
				if (fn_q == FN_ADD) begin
					if (hit)
						nxt = S_ED_WR;
					else if (last)
						nxt = (freev_q || !vld_q[k_q]) ? S_ED_WR : S_FIN;
					else
						nxt = S_ED_RD;
				end else begin
					nxt = last ? S_FIN : S_ED_RD;
				end
			end
			S_ED_WR: begin
				mem_wr = 1'b1;
				nxt    = S_FIN;
			end
			S_Q_DIF: nxt = S_SQ_GO;
			S_SQ_GO: begin
				mul_go = 1'b1;
				if (ax_q == 2'd3) begin
					mul_a = 64'(obs_q ? r_q : tol_q);
					mul_b = mul_a;
				end else begin
					mul_a = 64'(mag_sel);
					mul_b = 64'(mag_sel);
				end
				nxt = S_SQ_WT;
			end
			S_SQ_WT: begin
				if (mdone_q) begin
					if (ax_q != 2'd3)
						nxt = S_SQ_GO;
					else
						nxt = obs_q ? S_OB_CHK : S_AT_CHK;
				end
			end
			S_AT_CHK: nxt = (capf || (s_q > tol2_q)) ? S_AT_GO : S_OB_RD;
			S_AT_GO: begin
				mul_go = 1'b1;
				mul_a  = 64'(again_q);
				mul_b  = 64'(mag_sel);
				nxt    = S_AT_WT;
			end
			S_AT_WT: begin
				if (mdone_q)
					nxt = (ax_q == 2'd2) ? S_OB_RD : S_AT_GO;
			end
			S_OB_RD: begin
				if (vld_q[k_q]) begin
					mem_rd = 1'b1;
					nxt    = S_OB_DIF;
				end else if (last) begin
					nxt = S_FIN;
				end
			end
			S_OB_DIF: nxt = S_OB_OUT;
			S_OB_OUT: nxt = out_reach ? S_OB_NXT : S_SQ_GO;
			S_OB_CHK: begin
				if ((s_q > r2_q) || (s_q == 64'd0) || (s_q < tol2_q))
					nxt = S_OB_NXT;
				else
					nxt = S_SR_GO;
			end
			S_OB_NXT: nxt = last ? S_FIN : S_OB_RD;
			S_SR_GO: begin
				sqrt_go = 1'b1;
				nxt     = S_SR_WT;
			end
			S_SR_WT: if (sdone_q) nxt = S_DI_GO;
			S_DI_GO: begin
				div_go = 1'b1;
				nxt    = S_DI_WT;
			end
			S_DI_WT: if (ddone_q) nxt = S_DR_GO;
			S_DR_GO: begin
				div_go = 1'b1;
				div_d  = {1'b0, r_q};
				nxt    = S_DR_WT;
			end
			S_DR_WT: if (ddone_q) nxt = S_T_GO;
			S_T_GO: begin
				mul_go = 1'b1;
				if (ax_q == 2'd0) begin
					mul_a = 64'(invd_q - invr_q);
					mul_b = 64'(eg_q);
				end else begin
					mul_a = 64'(t_q);
					mul_b = 64'(invd_q);
				end
				nxt = S_T_WT;
			end
			S_T_WT: begin
				if (mdone_q)
					nxt = (ax_q == 2'd2) ? S_U_GO : S_T_GO;
			end
			S_U_GO: begin
				div_go  = 1'b1;
				div_n   = {mag_sel[30:0], 33'd0};
				div_cnt = DCNT_W'(U_BITS);
				nxt     = S_U_WT;
			end
			S_U_WT: if (ddone_q) nxt = S_M_GO;
			S_M_GO: begin
				mul_go = 1'b1;
				mul_a  = 64'(t_q);
				mul_b  = 64'(u_q);
				nxt    = S_M_WT;
			end
			S_M_WT: begin
				if (mdone_q)
					nxt = (ax_q == 2'd2) ? S_OB_NXT : S_U_GO;
			end
			S_FIN: if (out_load) nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr)
			obs_mem[slot_q] <= '{id: oid_q, cx: p_q[0], cy: p_q[1], cz: p_q[2],
				rad: rin_q, gain: gin_q};
		if (mem_rd)
			rd_q <= obs_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (state_q == S_CLR)
				vld_q <= '0;
			if (state_q == S_ED_CHK && fn_q == FN_REMOVE && hit)
				vld_q[k_q] <= 1'b0;
			if (state_q == S_ED_WR)
				vld_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					fn_q    <= func_t'(func);
					oid_q   <= obstacle_id;
					p_q[0]  <= pos_x;
					p_q[1]  <= pos_y;
					p_q[2]  <= pos_z;
					rin_q   <= influence_radius;
					gin_q   <= repulse_gain;
					k_q     <= '0;
					freev_q <= 1'b0;
					found_q <= 1'b0;
					full_q  <= 1'b0;
					for (int i = 0; i < 3; i++)
						acc_q[i] <= '0;
				end
			end
			S_ED_CHK: begin
				if (fn_q == FN_ADD && !hit && !vld_q[k_q] && !freev_q) begin
					slot_q  <= k_q;
					freev_q <= 1'b1;
				end
				if (fn_q == FN_ADD && !hit && last && !freev_q && vld_q[k_q])
					full_q <= 1'b1;
				if (hit) begin
					found_q <= 1'b1;
					if (fn_q == FN_ADD)
						slot_q <= k_q;
				end
				k_q <= k_q + 1'b1;
			end
			S_Q_DIF: begin
				for (int i = 0; i < 3; i++)
					dif_q[i] <= {p_q[i][31], p_q[i]} - {goal_q[i][31], goal_q[i]};
				ax_q  <= '0;
				obs_q <= 1'b0;
			end
			S_SQ_WT: begin
				if (mdone_q) begin
					if (ax_q == 2'd0)
						s_q <= prod_q[63:0];
					else if (ax_q != 2'd3)
						s_q <= s_q + prod_q[63:0];
					else if (obs_q)
						r2_q <= prod_q[63:0];
					else
						tol2_q <= prod_q[63:0];
					ax_q <= ax_q + 1'b1;
				end
			end
			S_AT_CHK: k_q <= '0;
			S_AT_WT: begin
				if (mdone_q) begin
					if (dif_q[ax_q][32])
						acc_q[ax_q] <= acc_q[ax_q] + ACC_W'(term_att[31:0]);
					else
						acc_q[ax_q] <= acc_q[ax_q] - ACC_W'(term_att[31:0]);
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
				end
			end
			S_OB_RD: begin
				if (!vld_q[k_q] && !last)
					k_q <= k_q + 1'b1;
			end
			S_OB_DIF: begin
				dif_q[0] <= {p_q[0][31], p_q[0]} - {rd_q.cx[31], rd_q.cx};
				dif_q[1] <= {p_q[1][31], p_q[1]} - {rd_q.cy[31], rd_q.cy};
				dif_q[2] <= {p_q[2][31], p_q[2]} - {rd_q.cz[31], rd_q.cz};
				r_q      <= rd_q.rad;
				eg_q     <= rd_q.gain;
			end
			S_OB_OUT: begin
				obs_q <= 1'b1;
				ax_q  <= '0;
			end
			S_OB_NXT: k_q <= k_q + 1'b1;
			S_SR_WT: if (sdone_q) q_q <= sres_q[31:0];
			S_DI_WT: if (ddone_q) invd_q <= dqo_q[ID_BITS-1:0];
			S_DR_WT: if (ddone_q) invr_q <= dqo_q[ID_BITS-1:0];
			S_T_WT: begin
				if (mdone_q) begin
					t_q  <= tstage[62:0];
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
				end
			end
			S_U_WT: if (ddone_q) u_q <= dqo_q[U_BITS-1:0];
			S_M_WT: begin
				if (mdone_q) begin
					if (dif_q[ax_q][32])
						acc_q[ax_q] <= acc_q[ax_q] - ACC_W'(term_rep[31:0]);
					else
						acc_q[ax_q] <= acc_q[ax_q] + ACC_W'(term_rep[31:0]);
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// 64x64 multiply from four 32x32 partial products
	assign pj = mc_q - 3'd1;
	assign sh = {1'b0, pj[1]} + {1'b0, pj[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
		end else begin
			mdone_q <= 1'b0;
			if (mul_go) begin
				mbusy_q <= 1'b1;
			end else if (mbusy_q && mc_q == 3'd4) begin
				mbusy_q <= 1'b0;
				mdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			ma_q   <= mul_a;
			mb_q   <= mul_b;
			mc_q   <= '0;
			prod_q <= '0;
		end else if (mbusy_q) begin
			if (!mc_q[2])
				pp_q <= (mc_q[1] ? ma_q[63:32] : ma_q[31:0]) *
					(mc_q[0] ? mb_q[63:32] : mb_q[31:0]);
			if (mc_q != 3'd0)
				prod_q <= prod_q + ({64'd0, pp_q} << {sh, 5'd0});
			mc_q <= mc_q + 3'd1;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {dr_q, dn_q[63]};
	assign rem_ge = (rem_sh >= {1'b0, dd_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (div_go) begin
				dbusy_q <= 1'b1;
			end else if (dbusy_q && dcnt_q == DCNT_W'(1)) begin
				dbusy_q <= 1'b0;
				ddone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			dn_q   <= div_n;
			dd_q   <= div_d;
			dr_q   <= '0;
			dqo_q  <= '0;
			dcnt_q <= div_cnt;
		end else if (dbusy_q) begin
			dr_q   <= rem_ge ? 32'(rem_sh - {1'b0, dd_q}) : rem_sh[31:0];
			dqo_q  <= {dqo_q[62:0], rem_ge};
			dn_q   <= {dn_q[62:0], 1'b0};
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// integer square root, two radicand bits per cycle
	assign strial = sres_q + sbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
		end else begin
			sdone_q <= 1'b0;
			if (sqrt_go) begin
				sbusy_q <= 1'b1;
			end else if (sbusy_q && sbit_q[0]) begin
				sbusy_q <= 1'b0;
				sdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sqrt_go) begin
			ss_q   <= s_q;
			sres_q <= '0;
			sbit_q <= 64'h4000_0000_0000_0000;
		end else if (sbusy_q) begin
			if (ss_q >= strial) begin
				ss_q   <= ss_q - strial;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 3; i++)
				fo_q[i] <= sat_out(acc_q[i]);
			fnd_o_q  <= found_q;
			full_o_q <= full_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign force_x    = fo_q[0];
	assign force_y    = fo_q[1];
	assign force_z    = fo_q[2];
	assign id_found   = fnd_o_q;
	assign table_full = full_o_q;

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go |-> !mbusy_q)
		else $error("multiply launched while busy");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !dbusy_q)
		else $error("divide launched while busy");

	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mdone_q, ddone_q, sdone_q}))
		else $error("two arithmetic units finished together");

	a_full_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && full_q) |-> (&vld_q))
		else $error("table full flagged with a free slot");

	a_wr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ED_WR) |=> vld_q[$past(slot_q)])
		else $error("written slot not marked valid");

endmodule
`default_nettype wire

/* verif/potential_field_velocity_checker.sv */
`default_nettype none
module potential_field_velocity_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [1:0]                    func,
	input  wire logic [15:0]                   obstacle_id,
	input  wire logic [31:0]                   pos_x,
	input  wire logic [31:0]                   pos_y,
	input  wire logic [31:0]                   pos_z,
	input  wire logic [30:0]                   influence_radius,
	input  wire logic [30:0]                   repulse_gain,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [31:0]                   force_x,
	input  wire logic [31:0]                   force_y,
	input  wire logic [31:0]                   force_z,
	input  wire logic                          id_found,
	input  wire logic                          table_full,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [pfv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	output int                                 errors,
	output int                                 pending
);
	import pfv_pkg::*;

	typedef struct {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
		logic        found;
		logic        full;
	} velocity_t;

	localparam logic [63:0] ONE_Q32 = 64'd1 << (2 * FRAC_BITS);

	longint      goal[3];
	logic [63:0] att_gain;
	logic [63:0] tol;
	logic        slot_used[MAX_OBS];
	logic [15:0] slot_id[MAX_OBS];
	longint      slot_c[MAX_OBS][3];
	logic [63:0] slot_rad[MAX_OBS];
	logic [63:0] slot_gain[MAX_OBS];
	velocity_t   velocity_q[$];

	function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] cap);
		logic [127:0] p;
		logic [63:0]  r;
		p = {64'd0, a} * {64'd0, b};
		if (|p[127:64+FRAC_BITS])
			return cap;
		r = p[63+FRAC_BITS:FRAC_BITS];
		return (r > cap) ? cap : r;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] s);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] absval(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic void field_velocity(input longint p[3], output longint acc[3]);
		longint      d[3];
		logic [63:0] tol2;
		logic [63:0] s;
		logic [63:0] q;
		logic [63:0] inv_d;
		logic [63:0] inv_r;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] m;
		logic        far;
		logic        out;
		tol2 = tol * tol;
		far = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			acc[i] = 0;
			d[i] = p[i] - goal[i];
			if (absval(d[i]) >= CAP_TERM)
				far = 1;
		end
		if (!far) begin
			for (int i = 0; i < 3; i++)
				s = s + absval(d[i]) * absval(d[i]);
			far = s > tol2;
		end
		if (far)
			for (int i = 0; i < 3; i++) begin
				m = scaled_product(att_gain, absval(d[i]), CAP_TERM);
				if (d[i] > 0)
					acc[i] = acc[i] - longint'(m);
				else if (d[i] < 0)
					acc[i] = acc[i] + longint'(m);
			end
		for (int k = 0; k < MAX_OBS; k++) begin
			if (slot_used[k]) begin
				out = 0;
				s = 0;
				for (int i = 0; i < 3; i++) begin
					d[i] = p[i] - slot_c[k][i];
					if (absval(d[i]) > slot_rad[k])
						out = 1;
				end
				if (!out) begin
					for (int i = 0; i < 3; i++)
						s = s + absval(d[i]) * absval(d[i]);
					if (!(s > slot_rad[k] * slot_rad[k] || s == 0 || s < tol2)) begin
						q = int_sqrt(s);
						inv_d = ONE_Q32 / q;
						inv_r = ONE_Q32 / slot_rad[k];
						t = scaled_product(inv_d - inv_r, slot_gain[k], CAP_STAGE);
						t = scaled_product(t, inv_d, CAP_STAGE);
						t = scaled_product(t, inv_d, CAP_STAGE);
						for (int i = 0; i < 3; i++) begin
							u = (absval(d[i]) << FRAC_BITS) / q;
							m = scaled_product(t, u, CAP_TERM);
							if (d[i] > 0)
								acc[i] = acc[i] + longint'(m);
							else if (d[i] < 0)
								acc[i] = acc[i] - longint'(m);
						end
					end
				end
			end
		end
	endfunction

	function automatic velocity_t apply_item(input func_t fn, input logic [15:0] id,
			input longint p[3], input logic [30:0] rad, input logic [30:0] gn);
		velocity_t r;
		longint    acc[3];
		int        slot;
		r = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
		case (fn)
			FN_QUERY: begin
				field_velocity(p, acc);
				r.fx = clamp32(acc[0]);
				r.fy = clamp32(acc[1]);
				r.fz = clamp32(acc[2]);
			end
			FN_ADD: begin
				slot = -1;
				for (int k = 0; k < MAX_OBS; k++)
					if (slot < 0 && slot_used[k] && slot_id[k] == id) begin
						slot = k;
						r.found = 1;
					end
				for (int k = 0; k < MAX_OBS; k++)
					if (slot < 0 && !slot_used[k])
						slot = k;
				if (slot < 0) begin
					r.full = 1;
				end else begin
					slot_used[slot] = 1;
					slot_id[slot] = id;
					for (int i = 0; i < 3; i++)
						slot_c[slot][i] = p[i];
					slot_rad[slot] = 64'(rad);
					slot_gain[slot] = 64'(gn);
				end
			end
			FN_REMOVE: begin
				for (int k = 0; k < MAX_OBS; k++)
					if (slot_used[k] && slot_id[k] == id) begin
						slot_used[k] = 0;
						r.found = 1;
					end
			end
			default: begin
				for (int k = 0; k < MAX_OBS; k++)
					slot_used[k] = 0;
			end
		endcase
		return r;
	endfunction

	assign pending = velocity_q.size();

	always @(posedge clk or negedge arst_n) begin
		velocity_t e;
		longint    p[3];
		if (!arst_n) begin
			goal = '{0, 0, 0};
			att_gain = 64'd65536;
			tol = 64'd66;
			for (int k = 0; k < MAX_OBS; k++)
				slot_used[k] = 0;
			velocity_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GOAL_X:   goal[0] = longint'($signed(cfg_data));
					CFG_GOAL_Y:   goal[1] = longint'($signed(cfg_data));
					CFG_GOAL_Z:   goal[2] = longint'($signed(cfg_data));
					CFG_ATT_GAIN: att_gain = 64'(cfg_data[30:0]);
					CFG_TOL:      tol = 64'(cfg_data[30:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (velocity_q.size() == 0) begin
					$display("%0t: result with nothing expected: fx %h fy %h fz %h",
						$time, force_x, force_y, force_z);
					errors++;
				end else begin
					e = velocity_q.pop_front();
					if (force_x !== e.fx) begin
						$display("%0t: force_x expected %h got %h", $time, e.fx, force_x);
						errors++;
					end
					if (force_y !== e.fy) begin
						$display("%0t: force_y expected %h got %h", $time, e.fy, force_y);
						errors++;
					end
					if (force_z !== e.fz) begin
						$display("%0t: force_z expected %h got %h", $time, e.fz, force_z);
						errors++;
					end
					if (id_found !== e.found) begin
						$display("%0t: id_found expected %b got %b", $time, e.found, id_found);
						errors++;
					end
					if (table_full !== e.full) begin
						$display("%0t: table_full expected %b got %b", $time, e.full,
							table_full);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				p[0] = longint'($signed(pos_x));
				p[1] = longint'($signed(pos_y));
				p[2] = longint'($signed(pos_z));
				velocity_q.insert(velocity_q.size(), apply_item(func_t'(func), obstacle_id, p,
					influence_radius, repulse_gain));
			end
		end
	end

endmodule
`default_nettype wire

/* verif/potential_field_velocity_core_tb.sv */
`default_nettype none
module potential_field_velocity_core_tb;
	import pfv_pkg::*;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 in_valid = 0;
	logic                 in_stall;
	logic [1:0]           func = FN_QUERY;
	logic [15:0]          obstacle_id = 0;
	logic [31:0]          pos_x = 0;
	logic [31:0]          pos_y = 0;
	logic [31:0]          pos_z = 0;
	logic [30:0]          influence_radius = 0;
	logic [30:0]          repulse_gain = 0;
	logic                 out_valid;
	logic                 out_stall = 0;
	logic [31:0]          force_x;
	logic [31:0]          force_y;
	logic [31:0]          force_z;
	logic                 id_found;
	logic                 table_full;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [31:0]          cfg_data = 0;
	int                   errors;
	int                   pending;
	logic                 quiet = 0;
	int                   stall_left = 0;
	int                   sent[4] = '{0, 0, 0, 0};
	int                   cfg_writes = 0;

	always #2 clk = ~clk;

	potential_field_velocity_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .obstacle_id(obstacle_id),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.influence_radius(influence_radius), .repulse_gain(repulse_gain),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.id_found(id_found), .table_full(table_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	potential_field_velocity_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .obstacle_id(obstacle_id),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.influence_radius(influence_radius), .repulse_gain(repulse_gain),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.id_found(id_found), .table_full(table_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	// hold the result port for a random number of cycles after each accepted result, unless quiet
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 0;
			if (out_valid && !out_stall && !quiet)
				stall_left <= $urandom_range(0, 13);
		end
	end

	task automatic send_item(input func_t fn, input logic [15:0] id, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [30:0] rad,
			input logic [30:0] gn);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= fn;
		obstacle_id <= id;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		influence_radius <= rad;
		repulse_gain <= gn;
		sent[fn]++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	function automatic logic [31:0] near_coord;
		return $urandom_range(0, 7) == 0 ? $urandom : 32'($signed($urandom_range(0, 1 << 19))
			- (1 << 18));
	endfunction

	task automatic random_item;
		int          pick;
		logic [15:0] id;
		logic [30:0] rad;
		logic [30:0] gn;
		pick = $urandom_range(0, 99);
		id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 21));
		rad = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 3 << 16));
		gn = ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
		if (pick < 2)
			send_item(FN_CLEAR, 16'($urandom), $urandom, $urandom, $urandom, 31'($urandom),
				31'($urandom));
		else if (pick < 17)
			send_item(FN_REMOVE, id, $urandom, $urandom, $urandom, 31'($urandom),
				31'($urandom));
		else if (pick < 47)
			send_item(FN_ADD, id, near_coord(), near_coord(), near_coord(), rad, gn);
		else
			send_item(FN_QUERY, 16'($urandom), near_coord(), near_coord(), near_coord(),
				31'($urandom), 31'($urandom));
	endtask

	initial begin
		#(200_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// default settings: goal at origin
		send_item(FN_QUERY, 0, 0, 0, 0, 0, 0);
		send_item(FN_QUERY, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0);
		send_item(FN_REMOVE, 16'hFFFF, 0, 0, 0, 0, 0);
		send_item(FN_ADD, 16'hFFFF, 32'h0001_0000, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_item(FN_QUERY, 0, 32'h0001_0000, 0, 0, 0, 0);
		send_item(FN_QUERY, 0, 32'h0001_0100, 32'hFFFF_FF00, 32'h0000_0100, 0, 0);
		send_item(FN_ADD, 16'hFFFF, 0, 32'h0002_0000, 0, 0, 31'h0001_0000);
		send_item(FN_QUERY, 0, 0, 32'h0002_8000, 0, 0, 0);
		for (int k = 0; k < MAX_OBS; k++)
			send_item(FN_ADD, 16'(k), 32'($signed(k - 8) << 15), 32'h0000_4000,
				32'hFFFF_C000, 31'h0002_0000, 31'h0000_8000);
		send_item(FN_QUERY, 0, 0, 0, 0, 0, 0);
		send_item(FN_REMOVE, 16'd3, 0, 0, 0, 0, 0);
		send_item(FN_CLEAR, 0, 0, 0, 0, 0, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_GOAL_X, 32'h0001_8000);
					write_reg(CFG_GOAL_Y, 32'hFFFE_0000);
					write_reg(CFG_GOAL_Z, 32'h0000_4000);
					write_reg(CFG_ATT_GAIN, 32'h0000_8000);
					write_reg(CFG_TOL, 32'h0000_0400);
				end
				1: begin
					write_reg(CFG_GOAL_X, 32'h7FFF_FFFF);
					write_reg(CFG_GOAL_Y, 32'h8000_0000);
					write_reg(CFG_GOAL_Z, $urandom);
					write_reg(CFG_ATT_GAIN, 32'hFFFF_FFFF);
					write_reg(CFG_TOL, 32'd0);
					write_reg({CFG_IDX_W{1'b1}}, $urandom);
				end
				2: begin
					write_reg(CFG_GOAL_X, $urandom);
					write_reg(CFG_GOAL_Y, $urandom);
					write_reg(CFG_GOAL_Z, 32'h8000_0000);
					write_reg(CFG_ATT_GAIN, 32'd0);
					write_reg(CFG_TOL, 32'h7FFF_FFFF);
				end
				default: begin
					write_reg(CFG_GOAL_X, 32'd0);
					write_reg(CFG_GOAL_Y, 32'd0);
					write_reg(CFG_GOAL_Z, 32'd0);
					write_reg(CFG_ATT_GAIN, $urandom);
					write_reg(CFG_TOL, 32'($urandom_range(0, 1 << 12)));
				end
			endcase
			cfg_valid <= 0;
			for (int n = 0; n < 140; n++) begin
				if (n % 35 == 0)
					quiet <= ($urandom_range(0, 2) == 0);
				random_item();
			end
			quiet <= 0;
			drain();
		end

		repeat (40) @(posedge clk);
		$display("Sent %0d queries, %0d adds, %0d removes, %0d clears; %0d register writes.",
			sent[FN_QUERY], sent[FN_ADD], sent[FN_REMOVE], sent[FN_CLEAR], cfg_writes);
		$display("Settings ran from reset defaults through extreme goals, gains and tolerances.");
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
sv/pfv_pkg.sv
sv/potential_field_velocity_core.sv
verif/potential_field_velocity_checker.sv
verif/potential_field_velocity_core_tb.sv
